// File: design/can_rmc_pkg.sv
package can_rmc_pkg;

    localparam int MSG_ENTRIES = 128;
    localparam int PGN_ENTRIES = 16;
    localparam int CHANNELS    = 2;

    localparam int CH_W   = 1;
    localparam int MSG_IW = (MSG_ENTRIES > 1) ? $clog2(MSG_ENTRIES) : 1;
    localparam int MSG_CW = $clog2(MSG_ENTRIES + 1);
    localparam int PGN_IW = (PGN_ENTRIES > 1) ? $clog2(PGN_ENTRIES) : 1;
    localparam int PGN_CW = $clog2(PGN_ENTRIES + 1);
    localparam int SCAN_W = (MSG_CW > PGN_CW) ? MSG_CW : PGN_CW;
    localparam int MSG_DEPTH = 2 ** (CH_W + MSG_IW);
    localparam int PGN_DEPTH = 2 ** (CH_W + PGN_IW);

    localparam logic [2:0] OP_SUB_ID  = 3'd0;
    localparam logic [2:0] OP_SUB_PGN = 3'd1;
    localparam logic [2:0] OP_RX      = 3'd2;
    localparam logic [2:0] OP_RD_ID   = 3'd3;
    localparam logic [2:0] OP_RD_PGN  = 3'd4;

    localparam logic [2:0] CFG_REQ_ID_A   = 3'd0;
    localparam logic [2:0] CFG_PGN_ONLY_A = 3'd1;
    localparam logic [2:0] CFG_FROM_ALL_A = 3'd2;
    localparam logic [2:0] CFG_REQ_ID_B   = 3'd3;
    localparam logic [2:0] CFG_PGN_ONLY_B = 3'd4;
    localparam logic [2:0] CFG_FROM_ALL_B = 3'd5;

    localparam logic [25:0] MASK_FULL     = 26'h3FFFFFF;
    localparam logic [25:0] MASK_FULL_ALL = 26'h3FF00FF;
    localparam logic [25:0] MASK_PGN      = 26'h3FFFF00;
    localparam logic [25:0] MASK_PGN_ALL  = 26'h3FF0000;
    localparam logic [28:0] REQ_ID_RESET  = 29'hEAFF28;
    localparam logic [23:0] PGN_LIMIT     = 24'h3FFFF;

    typedef struct packed {
        logic [31:0] cnt;
        logic [3:0]  len;
        logic [63:0] data;
    } msg_rec_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_MSCAN,
        S_MREAD,
        S_REQ,
        S_PSCAN,
        S_PREAD,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_pgn;
        logic msg_append;
        logic msg_update;
        logic msg_report;
        logic pgn_append;
        logic pgn_update;
        logic pgn_report;
        logic set_status;
        logic push;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       ch_ok;
        logic       msg_full;
        logic       pgn_full;
        logic       key_ok;
        logic       req_match;
        logic       scan_busy;
        logic       scan_hit;
    } stat_t;

endpackage

// File: design/can_rmc_ctrl.sv
module can_rmc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  can_rmc_pkg::stat_t  stat,
    output can_rmc_pkg::cmd_t   cmd
);

    can_rmc_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= can_rmc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            can_rmc_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = can_rmc_pkg::S_DISPATCH;
                end
            end
            can_rmc_pkg::S_DISPATCH: begin
                state_next = can_rmc_pkg::S_DONE;
                if (stat.ch_ok) begin
                    case (stat.op)
                        can_rmc_pkg::OP_SUB_ID: begin
                            if (!stat.msg_full) begin
                                cmd.scan_start = 1'b1;
                                state_next     = can_rmc_pkg::S_MSCAN;
                            end
                        end
                        can_rmc_pkg::OP_SUB_PGN: begin
                            if (stat.key_ok && !stat.pgn_full) begin
                                cmd.scan_start = 1'b1;
                                cmd.scan_pgn   = 1'b1;
                                state_next     = can_rmc_pkg::S_PSCAN;
                            end
                        end
                        can_rmc_pkg::OP_RX, can_rmc_pkg::OP_RD_ID: begin
                            cmd.scan_start = 1'b1;
                            state_next     = can_rmc_pkg::S_MSCAN;
                        end
                        can_rmc_pkg::OP_RD_PGN: begin
                            cmd.scan_start = 1'b1;
                            cmd.scan_pgn   = 1'b1;
                            state_next     = can_rmc_pkg::S_PSCAN;
                        end
                        default: state_next = can_rmc_pkg::S_DONE;
                    endcase
                end
            end
            can_rmc_pkg::S_MSCAN: begin
                if (!stat.scan_busy) begin
                    if (stat.op == can_rmc_pkg::OP_SUB_ID) begin
                        cmd.msg_append = !stat.scan_hit;
                        cmd.set_status = 1'b1;
                        state_next     = can_rmc_pkg::S_DONE;
                    end else if (stat.scan_hit) begin
                        state_next = can_rmc_pkg::S_MREAD;
                    end else if (stat.op == can_rmc_pkg::OP_RX) begin
                        state_next = can_rmc_pkg::S_REQ;
                    end else begin
                        state_next = can_rmc_pkg::S_DONE;
                    end
                end
            end
            can_rmc_pkg::S_MREAD: begin
                if (stat.op == can_rmc_pkg::OP_RX) begin
                    cmd.msg_update = 1'b1;
                    state_next     = can_rmc_pkg::S_REQ;
                end else begin
                    cmd.msg_report = 1'b1;
                    state_next     = can_rmc_pkg::S_DONE;
                end
            end
            can_rmc_pkg::S_REQ: begin
                if (stat.req_match) begin
                    cmd.scan_start = 1'b1;
                    cmd.scan_pgn   = 1'b1;
                    state_next     = can_rmc_pkg::S_PSCAN;
                end else begin
                    state_next = can_rmc_pkg::S_DONE;
                end
            end
            can_rmc_pkg::S_PSCAN: begin
                if (!stat.scan_busy) begin
                    if (stat.op == can_rmc_pkg::OP_SUB_PGN) begin
                        cmd.pgn_append = !stat.scan_hit;
                        cmd.set_status = 1'b1;
                        state_next     = can_rmc_pkg::S_DONE;
                    end else if (stat.scan_hit) begin
                        state_next = can_rmc_pkg::S_PREAD;
                    end else begin
                        state_next = can_rmc_pkg::S_DONE;
                    end
                end
            end
            can_rmc_pkg::S_PREAD: begin
                if (stat.op == can_rmc_pkg::OP_RX) begin
                    cmd.pgn_update = 1'b1;
                end else begin
                    cmd.pgn_report = 1'b1;
                end
                state_next = can_rmc_pkg::S_DONE;
            end
            can_rmc_pkg::S_DONE: begin
                if (!out_valid_reg || out_ready) begin
                    cmd.push   = 1'b1;
                    state_next = can_rmc_pkg::S_IDLE;
                end
            end
            default: state_next = can_rmc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        out_valid_next = cmd.push | (out_valid_reg & ~out_ready);
    end

endmodule

// File: design/can_rmc_dp.sv
module can_rmc_dp (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [2:0]         in_op,
    input  logic               in_channel,
    input  logic [28:0]        in_frame_id,
    input  logic [23:0]        in_pgn_key,
    input  logic [3:0]         in_frame_length,
    input  logic [63:0]        in_frame_data,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_idx,
    input  logic [31:0]        cfg_val,
    input  can_rmc_pkg::cmd_t  cmd,
    output can_rmc_pkg::stat_t stat,
    output logic               out_status,
    output logic [31:0]        out_count,
    output logic [3:0]         out_length,
    output logic [63:0]        out_data
);

    localparam int IW = can_rmc_pkg::MSG_IW;
    localparam int PW = can_rmc_pkg::PGN_IW;
    localparam int SW = can_rmc_pkg::SCAN_W;

    logic [2:0]  op_reg;
    logic        ch_reg;
    logic [28:0] id_reg;
    logic [23:0] key_reg;
    logic [3:0]  len_reg;
    logic [63:0] data_reg;

    logic [28:0] req_id_reg   [can_rmc_pkg::CHANNELS];
    logic        pgn_only_reg [can_rmc_pkg::CHANNELS];
    logic        from_all_reg [can_rmc_pkg::CHANNELS];

    logic [can_rmc_pkg::MSG_CW-1:0] msg_fill_reg [can_rmc_pkg::CHANNELS];
    logic [can_rmc_pkg::PGN_CW-1:0] pgn_fill_reg [can_rmc_pkg::CHANNELS];

    logic [28:0]           id_mem   [can_rmc_pkg::MSG_DEPTH];
    can_rmc_pkg::msg_rec_t rec_mem  [can_rmc_pkg::MSG_DEPTH];
    logic [17:0]           pgn_mem  [can_rmc_pkg::PGN_DEPTH];
    logic [31:0]           pcnt_mem [can_rmc_pkg::PGN_DEPTH];

    logic [28:0]           id_q;
    can_rmc_pkg::msg_rec_t rec_q;
    logic [17:0]           pgn_q;
    logic [31:0]           pcnt_q;

    logic          scan_busy_reg, scan_hit_reg, scan_pgn_reg, pend_reg;
    logic [SW-1:0] scan_idx_reg, pend_idx_reg, hit_idx_reg;
    logic [SW-1:0] scan_limit;
    logic [23:0]   pgn_cmp_key;
    logic          pend_match;

    logic [IW:0] msg_scan_addr, msg_hit_addr, msg_app_addr;
    logic [PW:0] pgn_scan_addr, pgn_hit_addr, pgn_app_addr;

    logic [28:0] rid;
    logic [25:0] m_sel, ma_sel;

    logic        res_status_reg;
    logic [31:0] res_count_reg;
    logic [3:0]  res_len_reg;
    logic [63:0] res_data_reg;
    logic        o_status_reg;
    logic [31:0] o_count_reg;
    logic [3:0]  o_len_reg;
    logic [63:0] o_data_reg;

    // latched item
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            ch_reg   <= in_channel;
            id_reg   <= in_frame_id;
            key_reg  <= in_pgn_key;
            len_reg  <= in_frame_length;
            data_reg <= in_frame_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_id_reg[0]   <= can_rmc_pkg::REQ_ID_RESET;
            req_id_reg[1]   <= can_rmc_pkg::REQ_ID_RESET;
            pgn_only_reg[0] <= 1'b0;
            pgn_only_reg[1] <= 1'b0;
            from_all_reg[0] <= 1'b0;
            from_all_reg[1] <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_idx)
                can_rmc_pkg::CFG_REQ_ID_A:   req_id_reg[0]   <= cfg_val[28:0];
                can_rmc_pkg::CFG_PGN_ONLY_A: pgn_only_reg[0] <= cfg_val[0];
                can_rmc_pkg::CFG_FROM_ALL_A: from_all_reg[0] <= cfg_val[0];
                can_rmc_pkg::CFG_REQ_ID_B:   req_id_reg[1]   <= cfg_val[28:0];
                can_rmc_pkg::CFG_PGN_ONLY_B: pgn_only_reg[1] <= cfg_val[0];
                can_rmc_pkg::CFG_FROM_ALL_B: from_all_reg[1] <= cfg_val[0];
                default: ;
            endcase
        end
    end

    assign msg_scan_addr = {ch_reg, scan_idx_reg[IW-1:0]};
    assign msg_hit_addr  = {ch_reg, hit_idx_reg[IW-1:0]};
    assign msg_app_addr  = {ch_reg, msg_fill_reg[ch_reg][IW-1:0]};
    assign pgn_scan_addr = {ch_reg, scan_idx_reg[PW-1:0]};
    assign pgn_hit_addr  = {ch_reg, hit_idx_reg[PW-1:0]};
    assign pgn_app_addr  = {ch_reg, pgn_fill_reg[ch_reg][PW-1:0]};

    // memories
    always_ff @(posedge aclk) begin
        if (cmd.msg_append) begin
            id_mem[msg_app_addr]  <= id_reg;
        end
        id_q <= id_mem[msg_scan_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.msg_append) begin
            rec_mem[msg_app_addr] <= '0;
        end else if (cmd.msg_update) begin
            rec_mem[msg_hit_addr] <= {rec_q.cnt + 32'd1, len_reg, data_reg};
        end
        rec_q <= rec_mem[msg_hit_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.pgn_append) begin
            pgn_mem[pgn_app_addr] <= key_reg[17:0];
        end
        pgn_q <= pgn_mem[pgn_scan_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.pgn_append) begin
            pcnt_mem[pgn_app_addr] <= '0;
        end else if (cmd.pgn_update) begin
            pcnt_mem[pgn_hit_addr] <= pcnt_q + 32'd1;
        end
        pcnt_q <= pcnt_mem[pgn_hit_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            msg_fill_reg[0] <= '0;
            msg_fill_reg[1] <= '0;
            pgn_fill_reg[0] <= '0;
            pgn_fill_reg[1] <= '0;
        end else begin
            if (cmd.msg_append) begin
                msg_fill_reg[ch_reg] <= msg_fill_reg[ch_reg] + 1'b1;
            end
            if (cmd.pgn_append) begin
                pgn_fill_reg[ch_reg] <= pgn_fill_reg[ch_reg] + 1'b1;
            end
        end
    end

    // linear search: issue one address a cycle, compare in the following cycle
    assign pgn_cmp_key = (op_reg == can_rmc_pkg::OP_RX) ? data_reg[23:0] : key_reg;
    assign scan_limit  = scan_pgn_reg ? SW'(pgn_fill_reg[ch_reg]) : SW'(msg_fill_reg[ch_reg]);
    assign pend_match  = scan_pgn_reg ? ({6'd0, pgn_q} == pgn_cmp_key) : (id_q == id_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_busy_reg <= 1'b0;
            scan_hit_reg  <= 1'b0;
            scan_pgn_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            scan_idx_reg  <= '0;
            pend_idx_reg  <= '0;
            hit_idx_reg   <= '0;
        end else if (cmd.scan_start) begin
            scan_busy_reg <= 1'b1;
            scan_hit_reg  <= 1'b0;
            scan_pgn_reg  <= cmd.scan_pgn;
            pend_reg      <= 1'b0;
            scan_idx_reg  <= '0;
        end else if (scan_busy_reg) begin
            if (pend_reg && pend_match) begin
                scan_busy_reg <= 1'b0;
                scan_hit_reg  <= 1'b1;
                hit_idx_reg   <= pend_idx_reg;
            end else if (scan_idx_reg == scan_limit) begin
                scan_busy_reg <= 1'b0;
            end else begin
                pend_reg     <= 1'b1;
                pend_idx_reg <= scan_idx_reg;
                scan_idx_reg <= scan_idx_reg + 1'b1;
            end
        end
    end

    // request id filter
    assign rid    = req_id_reg[ch_reg];
    assign m_sel  = pgn_only_reg[ch_reg] ? can_rmc_pkg::MASK_PGN : can_rmc_pkg::MASK_FULL;
    assign ma_sel = pgn_only_reg[ch_reg] ? can_rmc_pkg::MASK_PGN_ALL
                                         : can_rmc_pkg::MASK_FULL_ALL;

    always_comb begin
        stat.op        = op_reg;
        stat.ch_ok     = (32'(ch_reg) < 32'(can_rmc_pkg::CHANNELS));
        stat.msg_full  = (32'(msg_fill_reg[ch_reg]) >= 32'(can_rmc_pkg::MSG_ENTRIES));
        stat.pgn_full  = (32'(pgn_fill_reg[ch_reg]) >= 32'(can_rmc_pkg::PGN_ENTRIES));
        stat.key_ok    = (key_reg <= can_rmc_pkg::PGN_LIMIT);
        stat.req_match = ((id_reg[25:0] & m_sel) == (rid[25:0] & m_sel))
                       || (from_all_reg[ch_reg]
                           && ((id_reg[25:0] & ma_sel) == (rid[25:0] & ma_sel)));
        stat.scan_busy = scan_busy_reg;
        stat.scan_hit  = scan_hit_reg;
    end

    // result being built, then the output word
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            res_status_reg <= 1'b0;
            res_count_reg  <= '0;
            res_len_reg    <= '0;
            res_data_reg   <= '0;
        end else begin
            if (cmd.set_status) begin
                res_status_reg <= 1'b1;
            end
            if (cmd.msg_update) begin
                res_status_reg <= 1'b1;
                res_count_reg  <= rec_q.cnt + 32'd1;
            end
            if (cmd.msg_report) begin
                res_status_reg <= 1'b1;
                res_count_reg  <= rec_q.cnt;
                res_len_reg    <= rec_q.len;
                res_data_reg   <= rec_q.data;
            end
            if (cmd.pgn_report) begin
                res_status_reg <= 1'b1;
                res_count_reg  <= pcnt_q;
            end
        end
        if (cmd.push) begin
            o_status_reg <= res_status_reg;
            o_count_reg  <= res_count_reg;
            o_len_reg    <= res_len_reg;
            o_data_reg   <= res_data_reg;
        end
    end

    assign out_status = o_status_reg;
    assign out_count  = o_count_reg;
    assign out_length = o_len_reg;
    assign out_data   = o_data_reg;

endmodule

// File: design/can_rx_mailbox_request_counter.sv
// CAN receive mailbox with a request PGN counter, two bus channels.
// Input stream (s_): one word per operation: subscribe id, subscribe PGN,
// received frame, read by id or read by PGN, for the channel it names.
// Result stream (m_): exactly one word per input word, in order.
// Configuration channel (cfg_): index 0..5 selects request id, PGN-only
// and from-all settings of channel A then B; cfg_ready is always high.
// Write configuration only while no operation is in progress.
// Each word is accepted, dispatched and pushed; between dispatch and
// push come a linear search of the id table, the request filter for a
// received frame, a search of the PGN table for a matching request
// frame or PGN operation, and a record read-modify-write per hit. The
// search loop reads one table entry per cycle from a single RAM port,
// and that sets the rate; one operation is worked on at a time.
// Reset clears fill counts and handshakes and returns the settings to
// their reset values; table RAMs need no clearing because the records
// and counts of new entries are zeroed when they are appended.
// When the receiver stalls, the finished word holds in the output
// register, the next input word is still taken and processed, and it
// then waits until the output register frees.
module can_rx_mailbox_request_counter (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // op[2:0], channel[3], frame_id[32:4], pgn_key[56:33],
    // frame_length[60:57], frame_data[124:61], zero[127:125]
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[0], count[32:1], stored_length[36:33], stored_data[100:37],
    // zero[103:101]
    output logic [103:0] m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    can_rmc_pkg::cmd_t  cmd;
    can_rmc_pkg::stat_t stat;
    logic        o_status;
    logic [31:0] o_count;
    logic [3:0]  o_length;
    logic [63:0] o_data;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    can_rmc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    can_rmc_dp u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_op           (s_tdata[2:0]),
        .in_channel      (s_tdata[3]),
        .in_frame_id     (s_tdata[32:4]),
        .in_pgn_key      (s_tdata[56:33]),
        .in_frame_length (s_tdata[60:57]),
        .in_frame_data   (s_tdata[124:61]),
        .cfg_we          (cfg_valid),
        .cfg_idx         (cfg_index),
        .cfg_val         (cfg_data),
        .cmd             (cmd),
        .stat            (stat),
        .out_status      (o_status),
        .out_count       (o_count),
        .out_length      (o_length),
        .out_data        (o_data)
    );

    // pack the result word, lowest field first
    assign m_tdata = {3'b000, o_data, o_length, o_count, o_status};

endmodule

// File: dv/tb_top.sv
module tb_top;

    // Spare op codes that the block must ignore
    localparam logic [2:0] OP_SPARE_5 = 3'd5;
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    localparam int PHASES      = 7;
    localparam int PHASE_WORDS = 200;
    localparam int SETTLE      = 200;      // worst-case latency of one word, with margin
    localparam int LONG_HOLD   = 600;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct packed {
        logic [2:0]  op;
        logic        ch;
        logic [28:0] id;
        logic [23:0] key;
        logic [3:0]  len;
        logic [63:0] data;
    } frame_op_t;

    typedef struct packed {
        logic        status;
        logic [31:0] count;
        logic [3:0]  slen;
        logic [63:0] sdata;
    } mailbox_res_t;

    typedef struct {
        frame_op_t    op;
        bit           typed;
        mailbox_res_t res;
    } script_row_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    // op[2:0], channel[3], frame_id[32:4], pgn_key[56:33],
    // frame_length[60:57], frame_data[124:61], zero[127:125]
    logic [127:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // status[0], count[32:1], stored_length[36:33], stored_data[100:37],
    // zero[103:101]
    logic [103:0] m_tdata;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [31:0]  cfg_data;

    can_rx_mailbox_request_counter u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the mailbox state, per channel
    logic [28:0] mb_id    [2][can_rmc_pkg::MSG_ENTRIES];
    logic [3:0]  mb_len   [2][can_rmc_pkg::MSG_ENTRIES];
    logic [63:0] mb_data  [2][can_rmc_pkg::MSG_ENTRIES];
    logic [31:0] mb_cnt   [2][can_rmc_pkg::MSG_ENTRIES];
    int          mb_fill  [2];
    logic [17:0] rq_pgn   [2][can_rmc_pkg::PGN_ENTRIES];
    logic [31:0] rq_cnt   [2][can_rmc_pkg::PGN_ENTRIES];
    int          rq_fill  [2];
    logic [28:0] req_id   [2];
    logic        pgn_only [2];
    logic        from_all [2];

    mailbox_res_t expected_words[$];
    int           errors;
    int           cycles;
    bit           quiet;
    bit           long_hold_req;

    // Stimulus pools so that lookups hit and tables fill up
    logic [28:0] id_pool  [2][140];
    logic [17:0] pgn_pool [24];

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic int find_frame(int ch, logic [28:0] id);
        for (int i = 0; i < mb_fill[ch]; i++)
            if (mb_id[ch][i] == id) return i;
        return -1;
    endfunction

    function automatic int find_request(int ch, logic [23:0] key);
        for (int i = 0; i < rq_fill[ch]; i++)
            if ({6'd0, rq_pgn[ch][i]} == key) return i;
        return -1;
    endfunction

    function automatic mailbox_res_t mailbox_step(frame_op_t w);
        mailbox_res_t r;
        int           k;
        int           ch;
        logic [25:0]  m;
        logic [25:0]  ma;
        logic [25:0]  rid;
        r  = '0;
        ch = w.ch;
        case (w.op)
            can_rmc_pkg::OP_SUB_ID: if (mb_fill[ch] < can_rmc_pkg::MSG_ENTRIES) begin
                r.status = 1'b1;
                if (find_frame(ch, w.id) < 0) begin
                    mb_id[ch][mb_fill[ch]]   = w.id;
                    mb_len[ch][mb_fill[ch]]  = '0;
                    mb_data[ch][mb_fill[ch]] = '0;
                    mb_cnt[ch][mb_fill[ch]]  = '0;
                    mb_fill[ch]++;
                end
            end
            can_rmc_pkg::OP_SUB_PGN: if (w.key <= can_rmc_pkg::PGN_LIMIT &&
                                         rq_fill[ch] < can_rmc_pkg::PGN_ENTRIES) begin
                r.status = 1'b1;
                if (find_request(ch, w.key) < 0) begin
                    rq_pgn[ch][rq_fill[ch]] = w.key[17:0];
                    rq_cnt[ch][rq_fill[ch]] = '0;
                    rq_fill[ch]++;
                end
            end
            can_rmc_pkg::OP_RX: begin
                m   = pgn_only[ch] ? can_rmc_pkg::MASK_PGN : can_rmc_pkg::MASK_FULL;
                ma  = pgn_only[ch] ? can_rmc_pkg::MASK_PGN_ALL : can_rmc_pkg::MASK_FULL_ALL;
                rid = req_id[ch][25:0];
                k = find_frame(ch, w.id);
                if (k >= 0) begin
                    mb_len[ch][k]  = w.len;
                    mb_data[ch][k] = w.data;
                    mb_cnt[ch][k]  = mb_cnt[ch][k] + 32'd1;
                    r.status = 1'b1;
                    r.count  = mb_cnt[ch][k];
                end
                if ((w.id[25:0] & m) == (rid & m) ||
                    (from_all[ch] && (w.id[25:0] & ma) == (rid & ma))) begin
                    k = find_request(ch, w.data[23:0]);
                    if (k >= 0) rq_cnt[ch][k] = rq_cnt[ch][k] + 32'd1;
                end
            end
            can_rmc_pkg::OP_RD_ID: begin
                k = find_frame(ch, w.id);
                if (k >= 0) begin
                    r.status = 1'b1;
                    r.count  = mb_cnt[ch][k];
                    r.slen   = mb_len[ch][k];
                    r.sdata  = mb_data[ch][k];
                end
            end
            can_rmc_pkg::OP_RD_PGN: begin
                k = find_request(ch, w.key);
                if (k >= 0) begin
                    r.status = 1'b1;
                    r.count  = rq_cnt[ch][k];
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Clock, reset, cycle limit
    // ---------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d words outstanding", $time,
                     expected_words.size());
            $display("tb_top failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Result checker: compare every word against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        mailbox_res_t got;
        mailbox_res_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            // status sits in the lowest bit of the word
            got = {m_tdata[0], m_tdata[32:1], m_tdata[36:33], m_tdata[100:37]};
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, got);
                errors++;
            end else begin
                exp_w = expected_words.pop_front();
                if (got.status !== exp_w.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_w.status, got.status);
                    errors++;
                end
                if (got.count !== exp_w.count) begin
                    $display("%0t: count expected %0d actual %0d",
                             $time, exp_w.count, got.count);
                    errors++;
                end
                if (got.slen !== exp_w.slen) begin
                    $display("%0t: stored_length expected %0d actual %0d",
                             $time, exp_w.slen, got.slen);
                    errors++;
                end
                if (got.sdata !== exp_w.sdata) begin
                    $display("%0t: stored_data expected %h actual %h",
                             $time, exp_w.sdata, got.sdata);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Receiver: random back-pressure bursts, plus one long hold on request
    // ---------------------------------------------------------------
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                // hold off long enough for the block to fill and stall its input
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_tready <= 1'b1;
                @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // ---------------------------------------------------------------
    // Sender helpers
    // ---------------------------------------------------------------
    // Offer one word and hold until it is taken; valid stays high afterwards
    task automatic offer_word(frame_op_t w, bit typed, mailbox_res_t res);
        mailbox_res_t pred;
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, w.data, w.len, w.key, w.id, w.ch, w.op};
        do @(posedge aclk); while (!s_tready);
        pred = mailbox_step(w);
        expected_words.push_back(typed ? res : pred);
    endtask

    // Random idle burst after a word, or keep valid high for the next one
    task automatic sender_gap();
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Write all six registers back to back; only call while the block is idle
    task automatic write_settings(logic [31:0] rid_a, logic po_a, logic fa_a,
                                  logic [31:0] rid_b, logic po_b, logic fa_b);
        logic [31:0] vals [6];
        logic [2:0]  idx  [6];
        vals = '{rid_a, {31'd0, po_a}, {31'd0, fa_a},
                 rid_b, {31'd0, po_b}, {31'd0, fa_b}};
        idx  = '{can_rmc_pkg::CFG_REQ_ID_A, can_rmc_pkg::CFG_PGN_ONLY_A,
                 can_rmc_pkg::CFG_FROM_ALL_A, can_rmc_pkg::CFG_REQ_ID_B,
                 can_rmc_pkg::CFG_PGN_ONLY_B, can_rmc_pkg::CFG_FROM_ALL_B};
        for (int i = 0; i < 6; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            do @(posedge aclk); while (!cfg_ready);
            case (idx[i])
                can_rmc_pkg::CFG_REQ_ID_A:   req_id[0]   = vals[i][28:0];
                can_rmc_pkg::CFG_PGN_ONLY_A: pgn_only[0] = vals[i][0];
                can_rmc_pkg::CFG_FROM_ALL_A: from_all[0] = vals[i][0];
                can_rmc_pkg::CFG_REQ_ID_B:   req_id[1]   = vals[i][28:0];
                can_rmc_pkg::CFG_PGN_ONLY_B: pgn_only[1] = vals[i][0];
                can_rmc_pkg::CFG_FROM_ALL_B: from_all[1] = vals[i][0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // An id that lands near the channel's request id: same, new source,
    // new destination, both, or new priority bits
    function automatic logic [28:0] request_like_id(int ch);
        logic [28:0] v;
        v = req_id[ch];
        case ($urandom_range(0, 4))
            0: ;
            1: v[7:0]   = 8'($urandom);
            2: v[15:8]  = 8'($urandom);
            3: v[15:0]  = 16'($urandom);
            default: v[28:26] = 3'($urandom);
        endcase
        return v;
    endfunction

    function automatic frame_op_t random_word();
        frame_op_t w;
        int        sel;
        int        ch;
        w    = '0;
        ch   = $urandom_range(0, 1);
        w.ch = 1'(ch);
        sel  = $urandom_range(0, 99);
        if (sel < 25)      w.op = can_rmc_pkg::OP_SUB_ID;
        else if (sel < 33) w.op = can_rmc_pkg::OP_SUB_PGN;
        else if (sel < 70) w.op = can_rmc_pkg::OP_RX;
        else if (sel < 85) w.op = can_rmc_pkg::OP_RD_ID;
        else if (sel < 96) w.op = can_rmc_pkg::OP_RD_PGN;
        else case ($urandom_range(0, 2))
            0: w.op = OP_SPARE_5;
            1: w.op = OP_SPARE_6;
            default: w.op = OP_SPARE_7;
        endcase
        sel = $urandom_range(0, 9);
        if (sel < 6)      w.id = id_pool[ch][$urandom_range(0, 139)];
        else if (sel < 9) w.id = request_like_id(ch);
        else              w.id = 29'($urandom);
        w.key  = ($urandom_range(0, 6) == 0) ? 24'($urandom)
                                            : {6'd0, pgn_pool[$urandom_range(0, 23)]};
        w.len  = 4'($urandom);
        w.data = {$urandom, $urandom};
        if ($urandom_range(0, 9) < 7) w.data[23:0] = {6'd0, pgn_pool[$urandom_range(0, 23)]};
        return w;
    endfunction

    // ---------------------------------------------------------------
    // Directed script: read-off expectations typed in, the rest predicted
    // ---------------------------------------------------------------
    localparam mailbox_res_t NONE = '0;
    localparam mailbox_res_t TAKEN = '{status: 1'b1, count: 32'd0, slen: 4'd0, sdata: 64'd0};

    script_row_t script [$];

    function automatic frame_op_t mk(logic [2:0] op, logic ch, logic [28:0] id,
                                     logic [23:0] key, logic [3:0] len,
                                     logic [63:0] data);
        frame_op_t w;
        w = '{op: op, ch: ch, id: id, key: key, len: len, data: data};
        return w;
    endfunction

    task automatic add_row(frame_op_t w, bit typed, mailbox_res_t res);
        script_row_t row;
        row.op    = w;
        row.typed = typed;
        row.res   = res;
        script.push_back(row);
    endtask

    initial begin
        mailbox_res_t hit;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        aresetn   <= 1'b0;
        errors        = 0;
        cycles        = 0;
        quiet         = 1'b0;
        long_hold_req = 1'b0;
        for (int c = 0; c < 2; c++) begin
            mb_fill[c]  = 0;
            rq_fill[c]  = 0;
            req_id[c]   = can_rmc_pkg::REQ_ID_RESET;
            pgn_only[c] = 1'b0;
            from_all[c] = 1'b0;
            for (int i = 0; i < 140; i++) id_pool[c][i] = 29'($urandom);
        end
        pgn_pool[0] = '0;
        pgn_pool[1] = 18'h3FFFF;
        for (int i = 2; i < 24; i++) pgn_pool[i] = 18'($urandom);

        // lookups on empty tables, extremes, rejected PGNs, long frame, spare ops
        add_row(mk(can_rmc_pkg::OP_RD_ID,   0, 29'd0,        24'd0,      4'd0, 64'd0), 1, NONE);
        add_row(mk(can_rmc_pkg::OP_RD_PGN,  0, 29'd0,        24'd0,      4'd0, 64'd0), 1, NONE);
        add_row(mk(can_rmc_pkg::OP_SUB_ID,  0, 29'h1FFFFFFF, 24'hFFFFFF, 4'hF, '1),    1, TAKEN);
        add_row(mk(can_rmc_pkg::OP_SUB_ID,  0, 29'd0,        24'd0,      4'd0, 64'd0), 1, TAKEN);
        add_row(mk(can_rmc_pkg::OP_SUB_ID,  0, 29'h1FFFFFFF, 24'd0,      4'd0, 64'd0), 1, TAKEN);
        add_row(mk(can_rmc_pkg::OP_SUB_PGN, 0, 29'd0,        24'h03FFFF, 4'd0, 64'd0), 1, TAKEN);
        add_row(mk(can_rmc_pkg::OP_SUB_PGN, 0, 29'd0,        24'h040000, 4'd0, 64'd0), 1, NONE);
        add_row(mk(can_rmc_pkg::OP_SUB_PGN, 0, 29'h1FFFFFFF, 24'hFFFFFF, 4'hF, '1),    1, NONE);
        add_row(mk(can_rmc_pkg::OP_SUB_PGN, 0, 29'd0,        24'd0,      4'd0, 64'd0), 1, TAKEN);
        hit = '{status: 1'b1, count: 32'd1, slen: 4'd0, sdata: 64'd0};
        add_row(mk(can_rmc_pkg::OP_RX,      0, 29'h1FFFFFFF, 24'd0,      4'd8, '1),    1, hit);
        add_row(mk(can_rmc_pkg::OP_RX,      0, 29'd0,        24'd0,      4'hF, 64'd0), 1, hit);
        add_row(mk(can_rmc_pkg::OP_RD_ID,   0, 29'h1FFFFFFF, 24'd0,      4'd0, 64'd0), 1,
                '{status: 1'b1, count: 32'd1, slen: 4'd8, sdata: '1});
        add_row(mk(can_rmc_pkg::OP_RD_ID,   0, 29'd0,        24'd0,      4'd0, 64'd0), 1,
                '{status: 1'b1, count: 32'd1, slen: 4'hF, sdata: 64'd0});
        // request frame at the reset request id bumps the subscribed PGN
        add_row(mk(can_rmc_pkg::OP_RX,      0, 29'hEAFF28,   24'd0,      4'd3, 64'h03FFFF),
                0, NONE);
        add_row(mk(can_rmc_pkg::OP_RD_PGN,  0, 29'd0,        24'h03FFFF, 4'd0, 64'd0), 1,
                '{status: 1'b1, count: 32'd1, slen: 4'd0, sdata: 64'd0});
        add_row(mk(can_rmc_pkg::OP_RD_PGN,  0, 29'd0,        24'hFFFFFF, 4'd0, 64'd0), 1, NONE);
        add_row(mk(OP_SPARE_5,              0, 29'h1FFFFFFF, 24'h03FFFF, 4'd8, '1),    1, NONE);
        add_row(mk(OP_SPARE_6,              1, 29'd0,        24'd0,      4'd0, 64'd0), 1, NONE);
        add_row(mk(OP_SPARE_7,              1, 29'h1FFFFFFF, 24'hFFFFFF, 4'hF, '1),    1, NONE);
        // second channel keeps its own tables
        add_row(mk(can_rmc_pkg::OP_RD_ID,   1, 29'h1FFFFFFF, 24'd0,      4'd0, 64'd0), 1, NONE);
        add_row(mk(can_rmc_pkg::OP_SUB_ID,  1, 29'hEAFF28,   24'd0,      4'd0, 64'd0), 1, TAKEN);
        add_row(mk(can_rmc_pkg::OP_SUB_PGN, 1, 29'd0,        24'h001234, 4'd0, 64'd0), 1, TAKEN);
        add_row(mk(can_rmc_pkg::OP_RX,      1, 29'hEAFF28,   24'd0,      4'd5,
                   64'hA5A5_5A5A_FF00_1234), 0, NONE);
        add_row(mk(can_rmc_pkg::OP_RD_PGN,  1, 29'd0,        24'h001234, 4'd0, 64'd0), 0, NONE);
        add_row(mk(can_rmc_pkg::OP_RD_ID,   1, 29'hEAFF28,   24'd0,      4'd0, 64'd0), 0, NONE);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            offer_word(script[i].op, script[i].typed, script[i].res);
            sender_gap();
        end
        drain();

        for (int p = 0; p < PHASES; p++) begin
            // extremes first, then random settings; upper data bits exercise masking
            case (p)
                0: write_settings(32'h0, 1'b0, 1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1);
                1: write_settings(32'h1FFF_FFFF, 1'b1, 1'b0, 32'h0, 1'b0, 1'b1);
                2: write_settings($urandom, 1'b0, 1'b1, $urandom, 1'b1, 1'b0);
                3: write_settings(32'hE000_0000 | 32'(can_rmc_pkg::REQ_ID_RESET), 1'b1, 1'b1,
                                  32'(can_rmc_pkg::REQ_ID_RESET), 1'b0, 1'b0);
                default: write_settings($urandom, 1'($urandom), 1'($urandom),
                                        $urandom, 1'($urandom), 1'($urandom));
            endcase
            quiet = (p == PHASES - 1);
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (p == 2 && n == 20) long_hold_req = 1'b1;
                if (p == 4 && n == 100) begin
                    // pause until every outstanding result has come back
                    s_tvalid <= 1'b0;
                    while (expected_words.size() != 0) @(posedge aclk);
                end
                offer_word(random_word(), 1'b0, NONE);
                sender_gap();
            end
            drain();
        end

        if (errors == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
